/* rtl/core/bmmc_pkg.sv */
// Shared types, codes and sizes for the banked memory map controller.
package bmmc_pkg;

    // Request kinds
    localparam logic [2:0] REQ_MEM_RD  = 3'd0;
    localparam logic [2:0] REQ_MEM_WR  = 3'd1;
    localparam logic [2:0] REQ_IO_WR   = 3'd2;
    localparam logic [2:0] REQ_IO_RD   = 3'd3;
    localparam logic [2:0] REQ_ROM_LD  = 3'd4;

    // Expansion unit codes
    localparam logic [1:0] UNIT_NONE   = 2'd0;
    localparam logic [1:0] UNIT_SWITCH = 2'd1;
    localparam logic [1:0] UNIT_BANK   = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UROM = 1'd1;

    // I/O ports
    localparam logic [7:0] PORT_ROM_A = 8'hE0;
    localparam logic [7:0] PORT_BANK  = 8'hE2;
    localparam logic [7:0] PORT_ROM_B = 8'hE3;

    // Sizes
    localparam int unsigned ADDR_W       = 16;
    localparam int unsigned DATA_W       = 8;
    localparam int unsigned MAX_BANKS    = 4;
    localparam int unsigned EXT_BANKS_DEF = 4;
    localparam int unsigned BANK_BYTES   = 32768;
    localparam int unsigned MAIN_BYTES   = 65536;
    localparam int unsigned BASIC_BYTES  = 24576;
    localparam int unsigned USER_BYTES   = 8192;
    localparam logic [ADDR_W-1:0] LOW_END = 16'h6000;

    localparam logic [7:0] BANK_SEL_RST = 8'hF0;

    // Read data source for the result stage
    localparam logic [2:0] SRC_ZERO  = 3'd0;
    localparam logic [2:0] SRC_MAIN  = 3'd1;
    localparam logic [2:0] SRC_BASIC = 3'd2;
    localparam logic [2:0] SRC_USER  = 3'd3;
    localparam logic [2:0] SRC_EXT   = 3'd4;
    localparam logic [2:0] SRC_OPEN  = 3'd5;
    localparam logic [2:0] SRC_IO    = 3'd6;

    // Result stage control
    typedef struct packed {
        logic       done;
        logic       valid;
        logic [2:0] src;
        logic [1:0] bank;
    } res_ctl_t;

endpackage

/* rtl/core/banked_memory_map_controller.sv */
// Top level: memory map decode, bank/overlay state and result stage.
//
//  channel   | signals                                   | beat taken when
//  ----------+-------------------------------------------+----------------------
//  request   | start, busy, req_type, address, write_data | start && !busy
//  result    | done, read_data, read_valid               | every cycle done is high
//  config    | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid && cfg_ready
//
// One request per clock; busy stays low. The result of a request shows in the
// cycle after it is taken, for one cycle: the RAM read port registers the
// data at the accept edge and a source mux picks it up in that next cycle.
// Reset clears the bank register to 0xF0, ROM overlay on, other control and state registers to 0.
// The result side cannot stall, so nothing ever backs up.
module banked_memory_map_controller #(
    parameter int unsigned EXT_BANKS = bmmc_pkg::EXT_BANKS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [2:0]                         req_type,
    input  logic [bmmc_pkg::ADDR_W-1:0]        address,
    input  logic [bmmc_pkg::DATA_W-1:0]        write_data,
    output logic                               done,
    output logic [bmmc_pkg::DATA_W-1:0]        read_data,
    output logic                               read_valid,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bmmc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bmmc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int unsigned MAIN_AW  = $clog2(bmmc_pkg::MAIN_BYTES);
    localparam int unsigned BANK_AW  = $clog2(bmmc_pkg::BANK_BYTES);
    localparam int unsigned BASIC_AW = $clog2(bmmc_pkg::BASIC_BYTES);
    localparam int unsigned USER_AW  = $clog2(bmmc_pkg::USER_BYTES);

    logic [1:0] unit_reg;
    logic       urom_reg;
    logic [7:0] bank_sel_reg, bank_sel_next;
    logic       low_ram_reg, low_ram_next;
    bmmc_pkg::res_ctl_t ctl_reg, ctl_next;
    logic [7:0] io_data_reg, io_data_next;

    logic       accept;
    logic       is_rd, is_wr, is_iow, is_ior, is_ld;
    logic       low_area, in_basic, in_user;
    logic       unit1, unit2;
    logic [1:0] rd_bank;
    logic [7:0] port;

    logic [7:0] main_rdata, basic_rdata, user_rdata;
    logic [7:0] ext_rdata [EXT_BANKS];
    logic [7:0] ext_mux;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Request decode
    assign is_rd    = accept && (req_type == bmmc_pkg::REQ_MEM_RD);
    assign is_wr    = accept && (req_type == bmmc_pkg::REQ_MEM_WR);
    assign is_iow   = accept && (req_type == bmmc_pkg::REQ_IO_WR);
    assign is_ior   = accept && (req_type == bmmc_pkg::REQ_IO_RD);
    assign is_ld    = accept && (req_type == bmmc_pkg::REQ_ROM_LD);
    assign low_area = !address[15];
    assign in_basic = low_area && (address < bmmc_pkg::LOW_END);
    assign in_user  = low_area && !in_basic;
    assign unit1    = (unit_reg == bmmc_pkg::UNIT_SWITCH);
    assign unit2    = (unit_reg == bmmc_pkg::UNIT_BANK);
    assign port     = address[7:0];

    // Read bank: lowest set bit of the low nibble
    always_comb
    begin
        if (bank_sel_reg[0])
        begin
            rd_bank = 2'd0;
        end
        else if (bank_sel_reg[1])
        begin
            rd_bank = 2'd1;
        end
        else if (bank_sel_reg[2])
        begin
            rd_bank = 2'd2;
        end
        else
        begin
            rd_bank = 2'd3;
        end
    end

    // Next state and result control
    always_comb
    begin
        bank_sel_next  = bank_sel_reg;
        low_ram_next   = low_ram_reg;
        io_data_next   = io_data_reg;
        ctl_next.done  = accept;
        ctl_next.valid = is_rd || is_ior;
        ctl_next.src   = bmmc_pkg::SRC_ZERO;
        ctl_next.bank  = rd_bank;

        if (is_rd)
        begin
            if (!low_area)
            begin
                ctl_next.src = bmmc_pkg::SRC_MAIN;
            end
            else if (unit2 && (bank_sel_reg[3:0] != 4'd0))
            begin
                if ({1'b0, rd_bank} >= 3'(EXT_BANKS))
                begin
                    ctl_next.src = bmmc_pkg::SRC_OPEN;
                end
                else
                begin
                    ctl_next.src = bmmc_pkg::SRC_EXT;
                end
            end
            else if (low_ram_reg)
            begin
                ctl_next.src = bmmc_pkg::SRC_MAIN;
            end
            else if (in_basic)
            begin
                ctl_next.src = bmmc_pkg::SRC_BASIC;
            end
            else if (unit1 || unit2 || urom_reg)
            begin
                ctl_next.src = bmmc_pkg::SRC_USER;
            end
            else
            begin
                ctl_next.src = bmmc_pkg::SRC_MAIN;
            end
        end

        if (is_ior)
        begin
            ctl_next.src = bmmc_pkg::SRC_IO;
            io_data_next = (port == bmmc_pkg::PORT_BANK) ? ~bank_sel_reg : 8'd0;
        end

        if (is_iow)
        begin
            if ((port == bmmc_pkg::PORT_ROM_A) || (port == bmmc_pkg::PORT_ROM_B))
            begin
                if (unit1)
                begin
                    low_ram_next = 1'b0;
                end
            end
            else if (port == bmmc_pkg::PORT_BANK)
            begin
                if (unit1)
                begin
                    low_ram_next = 1'b1;
                end
                else if (unit2)
                begin
                    bank_sel_next = write_data;
                end
            end
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_reg     <= bmmc_pkg::UNIT_NONE;
            urom_reg     <= 1'b0;
            bank_sel_reg <= bmmc_pkg::BANK_SEL_RST;
            low_ram_reg  <= 1'b0;
            ctl_reg      <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    bmmc_pkg::CFG_UNIT: unit_reg <= cfg_data;
                    bmmc_pkg::CFG_UROM: urom_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            bank_sel_reg <= bank_sel_next;
            low_ram_reg  <= low_ram_next;
            ctl_reg      <= ctl_next;
        end
    end

    // I/O readback payload
    always_ff @(posedge clk)
    begin
        io_data_reg <= io_data_next;
    end

    // Main RAM: low-area writes go to the banks when the bank unit is fitted
    bmmc_ram #(
        .WIDTH (bmmc_pkg::DATA_W),
        .DEPTH (bmmc_pkg::MAIN_BYTES)
    ) u_main_ram (
        .clk   (clk),
        .en    (is_rd || is_wr),
        .we    (is_wr && !(low_area && unit2)),
        .addr  (address[MAIN_AW-1:0]),
        .wdata (write_data),
        .rdata (main_rdata)
    );

    // Basic ROM image
    bmmc_ram #(
        .WIDTH (bmmc_pkg::DATA_W),
        .DEPTH (bmmc_pkg::BASIC_BYTES)
    ) u_basic_rom (
        .clk   (clk),
        .en    (is_rd || (is_ld && in_basic)),
        .we    (is_ld && in_basic),
        .addr  (address[BASIC_AW-1:0]),
        .wdata (write_data),
        .rdata (basic_rdata)
    );

    // User ROM image
    bmmc_ram #(
        .WIDTH (bmmc_pkg::DATA_W),
        .DEPTH (bmmc_pkg::USER_BYTES)
    ) u_user_rom (
        .clk   (clk),
        .en    (is_rd || (is_ld && in_user)),
        .we    (is_ld && in_user),
        .addr  (address[USER_AW-1:0]),
        .wdata (write_data),
        .rdata (user_rdata)
    );

    // Expansion banks, each with its own write enable
    for (genvar b = 0; b < EXT_BANKS; b++)
    begin : g_bank
        bmmc_ram #(
            .WIDTH (bmmc_pkg::DATA_W),
            .DEPTH (bmmc_pkg::BANK_BYTES)
        ) u_bank_ram (
            .clk   (clk),
            .en    (is_rd || (is_wr && low_area && unit2 && bank_sel_reg[4 + b])),
            .we    (is_wr && low_area && unit2 && bank_sel_reg[4 + b]),
            .addr  (address[BANK_AW-1:0]),
            .wdata (write_data),
            .rdata (ext_rdata[b])
        );
    end

    // Bank read mux
    always_comb
    begin
        ext_mux = '0;
        for (int i = 0; i < EXT_BANKS; i++)
        begin
            if (ctl_reg.bank == 2'(i))
            begin
                ext_mux = ext_rdata[i];
            end
        end
    end

    // Result stage
    always_comb
    begin
        case (ctl_reg.src)
            bmmc_pkg::SRC_MAIN:  read_data = main_rdata;
            bmmc_pkg::SRC_BASIC: read_data = basic_rdata;
            bmmc_pkg::SRC_USER:  read_data = user_rdata;
            bmmc_pkg::SRC_EXT:   read_data = ext_mux;
            bmmc_pkg::SRC_OPEN:  read_data = 8'hFF;
            bmmc_pkg::SRC_IO:    read_data = io_data_reg;
            default:             read_data = 8'd0;
        endcase
    end

    assign done       = ctl_reg.done;
    assign read_valid = ctl_reg.valid;

endmodule

/* rtl/core/bmmc_ram.sv */
// Generic single-port RAM with registered read.
module bmmc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, or read into the output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

/* dv/bmmc_result_check.sv */
// Result checker for the memory map controller: predicts every result beat and compares.
module bmmc_result_check
    import bmmc_pkg::*;
#(
    parameter int unsigned EXT_BANKS = EXT_BANKS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic [2:0]            req_type,
    input  logic [ADDR_W-1:0]     address,
    input  logic [DATA_W-1:0]     write_data,
    input  logic                  done,
    input  logic [DATA_W-1:0]     read_data,
    input  logic                  read_valid,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ADDR_W-1:0] HIGH_START = 16'h8000;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              valid;
    } read_result_t;

    // Shadow of the address space and mapping state
    logic [7:0] main_mem  [MAIN_BYTES];
    logic [7:0] bank_mem  [MAX_BANKS*BANK_BYTES];
    logic [7:0] basic_mem [BASIC_BYTES];
    logic [7:0] user_mem  [USER_BYTES];
    logic [7:0] bank_reg  = BANK_SEL_RST;
    logic       low_ram   = 1'b0;
    logic [1:0] unit_cfg  = UNIT_NONE;
    logic       urom_cfg  = 1'b0;

    read_result_t expected_reads[$];

    // Byte seen by the CPU at address a under the current map
    function automatic logic [7:0] mapped_read(logic [ADDR_W-1:0] a);
        int b = 0;
        if (a >= HIGH_START)
            return main_mem[a];
        if (unit_cfg == UNIT_BANK && bank_reg[3:0] != 4'd0) begin
            // lowest set select bit wins
            while (!bank_reg[b])
                b++;
            if (b >= EXT_BANKS)
                return 8'hFF;
            return bank_mem[b*BANK_BYTES + a[14:0]];
        end
        if (low_ram)
            return main_mem[a];
        if (a < LOW_END)
            return basic_mem[a];
        if (unit_cfg == UNIT_SWITCH || unit_cfg == UNIT_BANK || urom_cfg)
            return user_mem[a - LOW_END];
        return main_mem[a];
    endfunction

    // Low-area writes with the bank unit fan out to every enabled bank
    function automatic void mapped_write(logic [ADDR_W-1:0] a, logic [7:0] d);
        if (a < HIGH_START && unit_cfg == UNIT_BANK) begin
            for (int b = 0; b < MAX_BANKS; b++)
                if (bank_reg[4+b] && b < EXT_BANKS)
                    bank_mem[b*BANK_BYTES + a[14:0]] = d;
        end
        else begin
            main_mem[a] = d;
        end
    endfunction

    function automatic void port_write(logic [7:0] port, logic [7:0] d);
        if (port == PORT_ROM_A || port == PORT_ROM_B) begin
            if (unit_cfg == UNIT_SWITCH)
                low_ram = 1'b0;
        end
        else if (port == PORT_BANK) begin
            if (unit_cfg == UNIT_SWITCH)
                low_ram = 1'b1;
            else if (unit_cfg == UNIT_BANK)
                bank_reg = d;
        end
    endfunction

    // Apply one request beat to the shadow, return the result it produces
    function automatic read_result_t apply_request(logic [2:0] kind, logic [ADDR_W-1:0] a,
                                                   logic [7:0] d);
        read_result_t r;
        r.data  = 8'h00;
        r.valid = 1'b0;
        case (kind)
            REQ_MEM_RD:
            begin
                r.data  = mapped_read(a);
                r.valid = 1'b1;
            end
            REQ_MEM_WR: mapped_write(a, d);
            REQ_IO_WR:  port_write(a[7:0], d);
            REQ_IO_RD:
            begin
                if (a[7:0] == PORT_BANK)
                    r.data = ~bank_reg;
                r.valid = 1'b1;
            end
            REQ_ROM_LD:
            begin
                if (a < LOW_END)
                    basic_mem[a] = d;
                else if (a < HIGH_START)
                    user_mem[a - LOW_END] = d;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Watch all three channels
    always @(posedge clk or negedge rst_n)
    begin
        read_result_t oldest;
        if (!rst_n) begin
            bank_reg   = BANK_SEL_RST;
            low_ram    = 1'b0;
            unit_cfg   = UNIT_NONE;
            urom_cfg   = 1'b0;
            fail_count = 0;
            expected_reads.delete();
        end
        else begin
            // a result at this edge always belongs to an earlier beat
            if (done) begin
                if (expected_reads.size() == 0) begin
                    $error("result beat with nothing pending: read_data %02h read_valid %0d",
                           read_data, read_valid);
                    fail_count++;
                end
                else begin
                    oldest = expected_reads.pop_front();
                    if (read_data !== oldest.data) begin
                        $error("read_data: expected %02h, got %02h", oldest.data, read_data);
                        fail_count++;
                    end
                    if (read_valid !== oldest.valid) begin
                        $error("read_valid: expected %0d, got %0d", oldest.valid, read_valid);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_UNIT)
                    unit_cfg = cfg_data;
                else if (cfg_index == CFG_UROM)
                    urom_cfg = cfg_data[0];
            end
            if (start && !busy)
                expected_reads.push_back(apply_request(req_type, address, write_data));
        end
        outstanding = expected_reads.size();
    end

endmodule

/* dv/banked_memory_map_controller_test.sv */
// Top testbench for the memory map controller: clock, reset, request and config stimulus.
module banked_memory_map_controller_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bmmc_pkg::*;

    localparam logic [ADDR_W-1:0] HIGH_START = 16'h8000;
    localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] REQ_UNUSED_LAST  = 3'd7;
    localparam logic [1:0] UNIT_SPARE       = 2'd3;
    localparam int RD_OK       = 0;
    localparam int RD_RAM_HOLE = 1;
    localparam int RD_ROM_HOLE = 2;
    localparam int POOL_SIZE       = 32;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int CYCLE_LIMIT     = 200000;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [2:0]            req_type;
    logic [ADDR_W-1:0]     address;
    logic [DATA_W-1:0]     write_data;
    logic                  done;
    logic [DATA_W-1:0]     read_data;
    logic                  read_valid;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    outstanding;
    int                    cycles = 0;

    // Which entries hold data, and the map state, so reads never hit unwritten bytes
    bit         main_set  [MAIN_BYTES];
    bit         bank_set  [MAX_BANKS*BANK_BYTES];
    bit         basic_set [BASIC_BYTES];
    bit         user_set  [USER_BYTES];
    logic [7:0] sh_bank    = BANK_SEL_RST;
    bit         sh_low_ram = 1'b0;
    logic [1:0] sh_unit    = UNIT_NONE;
    bit         sh_urom    = 1'b0;

    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
    logic [7:0]        map_ports [3] = '{PORT_ROM_A, PORT_BANK, PORT_ROM_B};
    logic [1:0]        unit_order[4] = '{UNIT_NONE, UNIT_SWITCH, UNIT_BANK, UNIT_SPARE};

    banked_memory_map_controller #(.EXT_BANKS(EXT_BANKS_DEF)) dut (.*);

    bmmc_result_check #(.EXT_BANKS(EXT_BANKS_DEF)) result_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Would a memory read of a touch a never-written byte, and of which kind
    function automatic int read_hole(logic [ADDR_W-1:0] a);
        int b = 0;
        if (a >= HIGH_START)
            return main_set[a] ? RD_OK : RD_RAM_HOLE;
        if (sh_unit == UNIT_BANK && sh_bank[3:0] != 4'd0) begin
            while (!sh_bank[b])
                b++;
            if (b >= EXT_BANKS_DEF)
                return RD_OK;
            return bank_set[b*BANK_BYTES + a[14:0]] ? RD_OK : RD_RAM_HOLE;
        end
        if (sh_low_ram)
            return main_set[a] ? RD_OK : RD_RAM_HOLE;
        if (a < LOW_END)
            return basic_set[a] ? RD_OK : RD_ROM_HOLE;
        if (sh_unit == UNIT_SWITCH || sh_unit == UNIT_BANK || sh_urom)
            return user_set[a - LOW_END] ? RD_OK : RD_ROM_HOLE;
        return main_set[a] ? RD_OK : RD_RAM_HOLE;
    endfunction

    // Track what an accepted beat wrote or remapped
    function automatic void note_request(logic [2:0] kind, logic [ADDR_W-1:0] a, logic [7:0] d);
        case (kind)
            REQ_MEM_WR:
            begin
                if (a < HIGH_START && sh_unit == UNIT_BANK) begin
                    for (int b = 0; b < EXT_BANKS_DEF; b++)
                        if (sh_bank[4+b])
                            bank_set[b*BANK_BYTES + a[14:0]] = 1'b1;
                end
                else begin
                    main_set[a] = 1'b1;
                end
            end
            REQ_IO_WR:
            begin
                if (a[7:0] == PORT_ROM_A || a[7:0] == PORT_ROM_B) begin
                    if (sh_unit == UNIT_SWITCH)
                        sh_low_ram = 1'b0;
                end
                else if (a[7:0] == PORT_BANK) begin
                    if (sh_unit == UNIT_SWITCH)
                        sh_low_ram = 1'b1;
                    else if (sh_unit == UNIT_BANK)
                        sh_bank = d;
                end
            end
            REQ_ROM_LD:
            begin
                if (a < LOW_END)
                    basic_set[a] = 1'b1;
                else if (a < HIGH_START)
                    user_set[a - LOW_END] = 1'b1;
            end
            default: ;
        endcase
    endfunction

    // Mostly back to back, some short gaps, a few long ones
    function automatic int idle_cycles(bit idle_on);
        int r;
        r = $urandom_range(99, 0);
        if (!idle_on || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(25, 4);
    endfunction

    // Present one request beat after gap idle cycles, return once it is taken
    task automatic send(logic [2:0] kind, logic [ADDR_W-1:0] a, logic [7:0] d, int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        req_type   <= kind;
        address    <= a;
        write_data <= d;
        do
            @(posedge clk);
        while (busy);
        note_request(kind, a, d);
    endtask

    // Register write, only once the block has drained
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        start <= 1'b0;
        repeat (2) @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_UNIT)
            sh_unit = val;
        else
            sh_urom = val[0];
    endtask

    // One random beat; reads that would hit a hole become the write that fills it
    task automatic random_item(bit idle_on);
        int                pick;
        logic [2:0]        kind;
        logic [ADDR_W-1:0] a;
        logic [7:0]        d;
        int                hole;
        pick = $urandom_range(99, 0);
        d    = 8'($urandom_range(255, 0));
        if ($urandom_range(9, 0) < 7)
            a = addr_pool[$urandom_range(POOL_SIZE-1, 0)];
        else
            a = 16'($urandom_range(16'hFFFF, 0));
        if (pick < 36)
            kind = REQ_MEM_RD;
        else if (pick < 64)
            kind = REQ_MEM_WR;
        else if (pick < 77)
            kind = REQ_IO_WR;
        else if (pick < 85)
            kind = REQ_IO_RD;
        else if (pick < 96)
            kind = REQ_ROM_LD;
        else
            kind = 3'($urandom_range(REQ_UNUSED_LAST, REQ_UNUSED_FIRST));

        // port beats mostly hit the mapping ports
        if ((kind == REQ_IO_WR || kind == REQ_IO_RD) && $urandom_range(9, 0) < 8)
            a[7:0] = map_ports[$urandom_range(2, 0)];
        // bank register values that line up reads with write enables
        if (kind == REQ_IO_WR && a[7:0] == PORT_BANK) begin
            if ($urandom_range(1, 0))
                d[7:4] = 4'hF;
            if ($urandom_range(9, 0) < 4)
                d[3:0] = 4'b0001 << $urandom_range(3, 0);
        end
        if (kind == REQ_ROM_LD && $urandom_range(9, 0) < 8)
            a[15] = 1'b0;

        if (kind == REQ_MEM_RD) begin
            hole = read_hole(a);
            if (hole == RD_ROM_HOLE)
                kind = REQ_ROM_LD;
            else if (hole == RD_RAM_HOLE)
                kind = REQ_MEM_WR;
        end
        send(kind, a, d, idle_cycles(idle_on));
    endtask

    // Stimulus and verdict
    initial
    begin
        rst_n      <= 1'b0;
        start      <= 1'b0;
        req_type   <= REQ_MEM_RD;
        address    <= '0;
        write_data <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= CFG_UNIT;
        cfg_data   <= UNIT_NONE;

        // address pool: region edges first, then random spots in each region
        addr_pool[0] = 16'h0000;
        addr_pool[1] = 16'h5FFF;
        addr_pool[2] = 16'h6000;
        addr_pool[3] = 16'h7FFF;
        addr_pool[4] = 16'h8000;
        addr_pool[5] = 16'hFFFF;
        for (int i = 6; i < POOL_SIZE; i++) begin
            case (i % 4)
                0: addr_pool[i] = 16'($urandom_range(16'h5FFF, 0));
                1: addr_pool[i] = 16'($urandom_range(16'h7FFF, 16'h6000));
                2: addr_pool[i] = 16'($urandom_range(16'hFFFF, 16'h8000));
                default: addr_pool[i] = 16'($urandom_range(16'h7FFF, 0));
            endcase
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: ROM window bounds, ignored loads above the ROM window, RAM writes, reads and I/O reads
        send(REQ_ROM_LD, 16'h0000, 8'h00, 0);
        send(REQ_ROM_LD, 16'h5FFF, 8'hFF, 0);
        send(REQ_ROM_LD, 16'h6000, 8'hA5, 0);
        send(REQ_ROM_LD, 16'h7FFF, 8'h5A, 0);
        send(REQ_ROM_LD, 16'h8000, 8'h11, 0);
        send(REQ_ROM_LD, 16'hFFFF, 8'h22, 0);
        send(REQ_MEM_WR, 16'h0000, 8'h3C, 0);
        send(REQ_MEM_WR, 16'h7FFF, 8'hC3, 0);
        send(REQ_MEM_WR, 16'hFFFF, 8'hFF, 0);
        send(REQ_MEM_RD, 16'h0000, 8'h00, 0);
        send(REQ_MEM_RD, 16'h5FFF, 8'h00, 0);
        send(REQ_MEM_RD, 16'h7FFF, 8'h00, 0);
        send(REQ_MEM_RD, 16'hFFFF, 8'h00, 0);
        send(REQ_IO_RD, 16'h00E2, 8'h00, 0);
        send(REQ_IO_RD, 16'hFFFF, 8'h00, 0);
        // unused request codes
        for (int k = REQ_UNUSED_FIRST; k <= REQ_UNUSED_LAST; k++)
            send(3'(k), 16'hFFFF, 8'hFF, 0);

        // switch unit: RAM over the low area, then ROM back, then RAM again
        write_reg(CFG_UNIT, UNIT_SWITCH);
        send(REQ_IO_WR, 16'h00E2, 8'h00, 0);
        send(REQ_MEM_RD, 16'h0000, 8'h00, 0);
        send(REQ_IO_WR, 16'hFFE3, 8'hFF, 0);
        send(REQ_MEM_RD, 16'h6000, 8'h00, 0);
        send(REQ_IO_WR, 16'h00E2, 8'h00, 0);
        // spare unit code still honors the RAM mapping left behind
        write_reg(CFG_UNIT, UNIT_SPARE);
        send(REQ_MEM_RD, 16'h7FFF, 8'h00, 0);
        // bank unit: broadcast write, read back from bank 0, register readback
        write_reg(CFG_UNIT, UNIT_BANK);
        send(REQ_IO_WR, 16'h00E2, 8'hF1, 0);
        send(REQ_MEM_WR, 16'h0000, 8'h77, 0);
        send(REQ_MEM_RD, 16'h0000, 8'h00, 0);
        send(REQ_IO_RD, 16'h00E2, 8'h00, 0);

        // Random phases: every unit code with both overlay settings, then random ones
        for (int p = 0; p < PHASES; p++) begin
            if (p < 8) begin
                write_reg(CFG_UNIT, unit_order[p/2]);
                write_reg(CFG_UROM, 2'(p % 2) | 2'($urandom_range(1, 0) << 1));
            end
            else begin
                write_reg(CFG_UNIT, 2'($urandom_range(3, 0)));
                write_reg(CFG_UROM, 2'($urandom_range(3, 0)));
            end
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                random_item(p % 3 != 1);
        end

        // drain
        start <= 1'b0;
        repeat (2) @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
